// ===== sv/rnfw_pkg.sv =====
package rnfw_pkg;

  localparam int PANEL_WIDTH_DEF  = 800;
  localparam int PANEL_HEIGHT_DEF = 480;

  localparam int POS_W        = 11;
  localparam int COORD_W      = 10;
  localparam int CI_W         = 3;
  localparam int CODE_W       = 4;
  localparam int NUM_COLOURS  = 6;
  localparam int BYTE_W       = 8;
  localparam int ADDR_FIELD_W = 18;
  localparam int WIDE_W       = 20;
  localparam int PADDR_W      = 5;
  localparam int PDATA_W      = 32;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  localparam logic [1:0] ST_WRITTEN    = 2'd0;
  localparam logic [1:0] ST_OOB        = 2'd1;
  localparam logic [1:0] ST_BAD_COLOUR = 2'd2;
  localparam logic [1:0] ST_READ       = 2'd3;

  localparam logic [1:0] ROT_FLIP_BOTH   = 2'd0;
  localparam logic [1:0] ROT_SWAP_FLIP_Y = 2'd1;
  localparam logic [1:0] ROT_IDENTITY    = 2'd2;
  localparam logic [1:0] ROT_SWAP_FLIP_X = 2'd3;

  localparam logic [2:0] REG_ROTATION      = 3'd0;
  localparam logic [2:0] REG_PALETTE_FIRST = 3'd1;
  localparam logic [2:0] REG_PALETTE_LAST  = 3'd6;

  typedef struct packed {
    logic [1:0]                         rotation;
    logic [NUM_COLOURS-1:0][CODE_W-1:0] palette;
  } cfg_t;

  typedef struct packed {
    logic capture;
    logic map;
    logic ram_rd;
    logic load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_sts_t;

endpackage

// ===== sv/rnfw_ram.sv =====
module rnfw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] addr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/rnfw_ctrl.sv =====
module rnfw_ctrl
  import rnfw_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  dp_sts_t   sts_i,
  output ctrl_cmd_t cmd_o
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_MAP   = 2'd1;
  localparam logic [1:0] S_RD    = 2'd2;
  localparam logic [1:0] S_MERGE = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_MAP;
        end
      end
      S_MAP: begin
        cmd_o.map = 1'b1;
        state_d   = S_RD;
      end
      S_RD: begin
        cmd_o.ram_rd = 1'b1;
        state_d      = S_MERGE;
      end
      S_MERGE: begin
        // hold until the output register can take the result
        if (sts_i.out_free) begin
          cmd_o.load = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef SYNTHESIS
  a_accept_to_map: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == S_MAP))
    else $error("accepted transaction did not enter mapping");

  a_load_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> sts_i.out_free)
    else $error("result loaded over an unaccepted transaction");

  a_map_to_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MAP) |=> (state_q == S_RD))
    else $error("mapping not followed by store read");
`endif

endmodule

// ===== sv/rnfw_dp.sv =====
module rnfw_dp
  import rnfw_pkg::*;
#(
  parameter int PANEL_WIDTH  = PANEL_WIDTH_DEF,
  parameter int PANEL_HEIGHT = PANEL_HEIGHT_DEF,
  localparam int ROW_BYTES   = (PANEL_WIDTH + 1) / 2,
  localparam int STORE_BYTES = ROW_BYTES * PANEL_HEIGHT,
  localparam int ADDR_W      = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  ctrl_cmd_t                 cmd_i,
  output dp_sts_t                   sts_o,
  input  cfg_t                      cfg_i,
  input  logic                      op_i,
  input  logic signed [POS_W-1:0]   pos_x_i,
  input  logic signed [POS_W-1:0]   pos_y_i,
  input  logic [CI_W-1:0]           colour_index_i,
  input  logic [ADDR_FIELD_W-1:0]   read_address_i,
  output logic                      ram_we_o,
  output logic                      ram_re_o,
  output logic [ADDR_W-1:0]         ram_addr_o,
  output logic [BYTE_W-1:0]         ram_wdata_o,
  input  logic [BYTE_W-1:0]         ram_rdata_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [1:0]                status_o,
  output logic [ADDR_FIELD_W-1:0]   byte_address_o,
  output logic [BYTE_W-1:0]         byte_value_o
);

  localparam logic [COORD_W-1:0] WIDTH_M1  = COORD_W'(PANEL_WIDTH - 1);
  localparam logic [COORD_W-1:0] HEIGHT_M1 = COORD_W'(PANEL_HEIGHT - 1);

  // captured transaction
  logic                    op_q;
  logic [POS_W-1:0]        x_q, y_q;
  logic [CI_W-1:0]         ci_q;
  logic [ADDR_FIELD_W-1:0] ra_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q <= op_i;
      x_q  <= pos_x_i;
      y_q  <= pos_y_i;
      ci_q <= colour_index_i;
      ra_q <= read_address_i;
    end
  end

  // rotation, bounds and address
  logic [COORD_W-1:0]      x10, y10, px, py;
  logic [POS_W-1:0]        user_w, user_h;
  logic                    oob, bad_colour, ra_in_range;
  logic [WIDE_W-1:0]       row_off, wr_addr, ra_wide;

  logic [1:0]              status_q, status_d;
  logic [ADDR_FIELD_W-1:0] baddr_q, baddr_d;
  logic [ADDR_W-1:0]       addr_q, addr_d;
  logic                    sub_q, sub_d;
  logic [CODE_W-1:0]       code_q, code_d;
  logic                    need_ram_q, need_ram_d;
  logic                    is_write_q, is_write_d;

  assign x10 = x_q[COORD_W-1:0];
  assign y10 = y_q[COORD_W-1:0];

  always_comb begin
    if (cfg_i.rotation[0]) begin
      user_w = POS_W'(PANEL_HEIGHT);
      user_h = POS_W'(PANEL_WIDTH);
    end else begin
      user_w = POS_W'(PANEL_WIDTH);
      user_h = POS_W'(PANEL_HEIGHT);
    end
  end

  assign oob = x_q[POS_W-1] || y_q[POS_W-1] ||
               ({1'b0, x10} >= user_w) || ({1'b0, y10} >= user_h);
  assign bad_colour = (ci_q > CI_W'(NUM_COLOURS - 1));

  always_comb begin
    unique case (cfg_i.rotation)
      ROT_FLIP_BOTH: begin
        px = WIDTH_M1 - x10;
        py = HEIGHT_M1 - y10;
      end
      ROT_SWAP_FLIP_Y: begin
        px = y10;
        py = HEIGHT_M1 - x10;
      end
      ROT_SWAP_FLIP_X: begin
        px = WIDTH_M1 - y10;
        py = x10;
      end
      default: begin
        px = x10;
        py = y10;
      end
    endcase
  end

  assign row_off     = WIDE_W'(py) * WIDE_W'(ROW_BYTES);
  assign wr_addr     = row_off + WIDE_W'(px[COORD_W-1:1]);
  assign ra_wide     = WIDE_W'(ra_q);
  assign ra_in_range = (ra_wide < WIDE_W'(STORE_BYTES));

  always_comb begin
    status_d   = ST_WRITTEN;
    baddr_d    = '0;
    addr_d     = ra_wide[ADDR_W-1:0];
    sub_d      = px[0];
    code_d     = '0;
    need_ram_d = 1'b0;
    is_write_d = 1'b0;
    priority if (op_q == OP_READ) begin
      status_d   = ST_READ;
      baddr_d    = ra_q;
      need_ram_d = ra_in_range;
    end else if (oob) begin
      status_d = ST_OOB;
    end else if (bad_colour) begin
      status_d = ST_BAD_COLOUR;
    end else begin
      status_d   = ST_WRITTEN;
      baddr_d    = ADDR_FIELD_W'(wr_addr);
      addr_d     = wr_addr[ADDR_W-1:0];
      code_d     = cfg_i.palette[ci_q];
      need_ram_d = 1'b1;
      is_write_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.map) begin
      status_q   <= status_d;
      baddr_q    <= baddr_d;
      addr_q     <= addr_d;
      sub_q      <= sub_d;
      code_q     <= code_d;
      need_ram_q <= need_ram_d;
      is_write_q <= is_write_d;
    end
  end

  // nibble merge: even column in the high nibble
  logic [BYTE_W-1:0] merged, value;

  assign merged = sub_q ? {ram_rdata_i[BYTE_W-1:CODE_W], code_q}
                        : {code_q, ram_rdata_i[CODE_W-1:0]};

  always_comb begin
    priority if (!need_ram_q) begin
      value = '0;
    end else if (is_write_q) begin
      value = merged;
    end else begin
      value = ram_rdata_i;
    end
  end

  assign ram_re_o    = cmd_i.ram_rd && need_ram_q;
  assign ram_we_o    = cmd_i.load && is_write_q;
  assign ram_addr_o  = addr_q;
  assign ram_wdata_o = merged;

  // output register
  logic                    out_valid_q, out_valid_d;
  logic [1:0]              out_status_q;
  logic [ADDR_FIELD_W-1:0] out_addr_q;
  logic [BYTE_W-1:0]       out_value_q;

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_status_q <= status_q;
      out_addr_q   <= baddr_q;
      out_value_q  <= value;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign byte_address_o = out_addr_q;
  assign byte_value_o   = out_value_q;

  assign sts_o.out_free = !out_valid_q || !out_stall_i;

`ifndef SYNTHESIS
  a_load_shows_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |=> out_valid_o)
    else $error("loaded result not presented");
`endif

endmodule

// ===== sv/rotated_nibble_framebuffer_writer_top.sv =====
// A result leaves the output register after mapping, store read and merge,
// which waits while that register is held. A new transaction is taken only
// after capture, mapping, store read and merge on the single store port.
// Reset (asynchronous, active low) clears the controller, output valid and
// configuration registers to their defaults; the frame store is not cleared.
module rotated_nibble_framebuffer_writer_top
  import rnfw_pkg::*;
#(
  parameter int PANEL_WIDTH  = PANEL_WIDTH_DEF,
  parameter int PANEL_HEIGHT = PANEL_HEIGHT_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic                    op_i,
  input  logic signed [POS_W-1:0] pos_x_i,
  input  logic signed [POS_W-1:0] pos_y_i,
  input  logic [CI_W-1:0]         colour_index_i,
  input  logic [ADDR_FIELD_W-1:0] read_address_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [1:0]              status_o,
  output logic [ADDR_FIELD_W-1:0] byte_address_o,
  output logic [BYTE_W-1:0]       byte_value_o,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [PADDR_W-1:0]      paddr,
  input  logic [PDATA_W-1:0]      pwdata,
  output logic [PDATA_W-1:0]      prdata,
  output logic                    pready
);

  localparam int ROW_BYTES   = (PANEL_WIDTH + 1) / 2;
  localparam int STORE_BYTES = ROW_BYTES * PANEL_HEIGHT;
  localparam int ADDR_W      = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;

  // register file
  cfg_t       cfg_q, cfg_d;
  logic [2:0] reg_idx;
  logic       reg_wr;

  assign reg_idx = paddr[PADDR_W-1:2];
  assign reg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (reg_wr) begin
      priority if (reg_idx == REG_ROTATION) begin
        cfg_d.rotation = pwdata[1:0];
      end else if (reg_idx <= REG_PALETTE_LAST) begin
        cfg_d.palette[3'(reg_idx - REG_PALETTE_FIRST)] = pwdata[CODE_W-1:0];
      end else begin
        cfg_d = cfg_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rotation <= ROT_FLIP_BOTH;
      for (int i = 0; i < NUM_COLOURS; i++) begin
        cfg_q.palette[i] <= CODE_W'(i);
      end
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    priority if (reg_idx == REG_ROTATION) begin
      prdata = PDATA_W'(cfg_q.rotation);
    end else if (reg_idx <= REG_PALETTE_LAST) begin
      prdata = PDATA_W'(cfg_q.palette[3'(reg_idx - REG_PALETTE_FIRST)]);
    end else begin
      prdata = '0;
    end
  end

  ctrl_cmd_t         cmd;
  dp_sts_t           sts;
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_addr;
  logic [BYTE_W-1:0] ram_wdata, ram_rdata;

  rnfw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rnfw_dp #(
    .PANEL_WIDTH  (PANEL_WIDTH),
    .PANEL_HEIGHT (PANEL_HEIGHT)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .cfg_i          (cfg_q),
    .op_i           (op_i),
    .pos_x_i        (pos_x_i),
    .pos_y_i        (pos_y_i),
    .colour_index_i (colour_index_i),
    .read_address_i (read_address_i),
    .ram_we_o       (ram_we),
    .ram_re_o       (ram_re),
    .ram_addr_o     (ram_addr),
    .ram_wdata_o    (ram_wdata),
    .ram_rdata_i    (ram_rdata),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .byte_address_o (byte_address_o),
    .byte_value_o   (byte_value_o)
  );

  rnfw_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (STORE_BYTES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

endmodule
